@@ src/rtab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtab_pkg
// Shared types and constants of the tinted additive RGB565 blender.
// ----------------------------------------------------------------------------
package rtab_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register select is paddr bit 2 (byte addresses 0 and 4)
  localparam logic REG_TINT  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  localparam logic [15:0] TINT_RST   = 16'hFFFF;
  localparam logic [8:0]  ALPHA_RST  = 9'd256;
  localparam logic [8:0]  FULL_ALPHA = 9'd256;

  localparam logic [8:0] SAT_RB = 9'h0F8;
  localparam logic [8:0] SAT_G  = 9'h0FC;

  // per-stage load strobes of the datapath
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

endpackage

@@ src/rtab_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtab_if
// Valid/ready channels: source/destination pixel pair in, blended pixel out.
// ----------------------------------------------------------------------------
interface rtab_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] source_pixel;
  logic [15:0] dest_pixel;

  modport source (output valid, output source_pixel, output dest_pixel, input ready);
  modport sink (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

interface rtab_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blended_pixel;
  logic        write_enable;

  modport source (output valid, output blended_pixel, output write_enable, input ready);
  modport sink (input valid, input blended_pixel, input write_enable, output ready);
endinterface

@@ src/rtab_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtab_datapath
// Three register stages: coverage x alpha, tint x weight, scale and blend.
// ----------------------------------------------------------------------------
module rtab_datapath (
  input  logic                clk,
  input  rtab_pkg::pipe_ctrl_t ctrl,
  input  logic [15:0]         source_pixel,
  input  logic [15:0]         dest_pixel,
  input  logic [15:0]         tint_color,
  input  logic [8:0]          alpha_level,
  output logic [15:0]         blended_pixel,
  output logic                write_enable
);

  function automatic logic [7:0] widen_r(input logic [15:0] p);
    return {p[15:11], p[15:13]};
  endfunction

  function automatic logic [7:0] widen_g(input logic [15:0] p);
    return {p[10:5], p[10:9]};
  endfunction

  function automatic logic [7:0] widen_b(input logic [15:0] p);
    return {p[4:0], p[4:2]};
  endfunction

  // floor(p / 65280): drop 8 bits, then divide by 255 via reciprocal
  function automatic logic [7:0] div_scale(input logic [23:0] p);
    logic [16:0] s;
    s = {1'b0, p[23:8]} + {9'b0, p[23:16]} + 17'd1;
    return s[15:8];
  endfunction

  // stage 1
  logic [7:0]  cov;
  logic [8:0]  alpha_c;
  logic [16:0] k_full;
  logic [15:0] s1_k_r;
  logic [15:0] s1_dst_r;
  logic        s1_zero_r;

  assign cov     = widen_r(source_pixel);
  assign alpha_c = (alpha_level > rtab_pkg::FULL_ALPHA) ? rtab_pkg::FULL_ALPHA : alpha_level;
  assign k_full  = alpha_c * cov;

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      s1_k_r    <= k_full[15:0];
      s1_dst_r  <= dest_pixel;
      s1_zero_r <= (source_pixel[15:11] == 5'd0);
    end
  end

  // stage 2
  logic [23:0] s2_pr_r;
  logic [23:0] s2_pg_r;
  logic [23:0] s2_pb_r;
  logic [15:0] s2_dst_r;
  logic        s2_zero_r;

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      s2_pr_r   <= widen_r(tint_color) * s1_k_r;
      s2_pg_r   <= widen_g(tint_color) * s1_k_r;
      s2_pb_r   <= widen_b(tint_color) * s1_k_r;
      s2_dst_r  <= s1_dst_r;
      s2_zero_r <= s1_zero_r;
    end
  end

  // stage 3
  logic [7:0]  qr, qg, qb;
  logic [15:0] tinted;
  logic [8:0]  sum_r, sum_g, sum_b;
  logic [8:0]  sat_r, sat_g, sat_b;
  logic [15:0] blend_nxt;
  logic [15:0] out_pix_r;
  logic        out_we_r;

  always_comb begin
    qr     = div_scale(s2_pr_r);
    qg     = div_scale(s2_pg_r);
    qb     = div_scale(s2_pb_r);
    tinted = {qr[7:3], qg[7:2], qb[7:3]};
    sum_r  = {1'b0, widen_r(tinted)} + {1'b0, widen_r(s2_dst_r)};
    sum_g  = {1'b0, widen_g(tinted)} + {1'b0, widen_g(s2_dst_r)};
    sum_b  = {1'b0, widen_b(tinted)} + {1'b0, widen_b(s2_dst_r)};
    sat_r  = (sum_r > rtab_pkg::SAT_RB) ? rtab_pkg::SAT_RB : sum_r;
    sat_g  = (sum_g > rtab_pkg::SAT_G)  ? rtab_pkg::SAT_G  : sum_g;
    sat_b  = (sum_b > rtab_pkg::SAT_RB) ? rtab_pkg::SAT_RB : sum_b;
    blend_nxt = {sat_r[7:3], sat_g[7:2], sat_b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      out_pix_r <= s2_zero_r ? s2_dst_r : blend_nxt;
      out_we_r  <= !s2_zero_r;
    end
  end

  assign blended_pixel = out_pix_r;
  assign write_enable  = out_we_r;

endmodule

@@ src/rgb565_tinted_additive_blend_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_tinted_additive_blend_top
// Tinted additive blend of an RGB565 pixel stream with coverage from red.
// ----------------------------------------------------------------------------
// in_ch carries a source/destination pixel pair, out_ch the blended pixel
// and a write enable (low when source coverage is zero, pixel = destination).
// A transfer happens on a clock edge with valid and ready both high.
// Each pixel passes through three register stages (coverage x alpha
// multiply, tint x weight multiply, scale and saturating add). Throughput
// is one pixel per clock while the receiver does not stall: each stage
// takes a new pixel every cycle unless it is full and its successor holds.
// When the receiver stalls, each stage holds and empty stages still fill, so
// in_ch keeps taking pixels until the pipeline is full.
// Tint colour and alpha are written through the cfg_ APB port (tint at byte
// 0, alpha at byte 4) by the user only while no pixel is in flight, which
// the block does not enforce; pready is always high. Synchronous reset
// (rst_n low) empties the pipeline, sets tint to 0xFFFF and alpha to 256 (full strength).
// ----------------------------------------------------------------------------
module rgb565_tinted_additive_blend_top (
  input  logic                         clk,
  input  logic                         rst_n,
  rtab_in_if.sink                      in_ch,
  rtab_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rtab_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rtab_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rtab_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  // configuration registers
  logic [15:0] tint_r;
  logic [8:0]  alpha_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_r  <= rtab_pkg::TINT_RST;
      alpha_r <= rtab_pkg::ALPHA_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rtab_pkg::REG_TINT:  tint_r  <= cfg_pwdata[15:0];
        rtab_pkg::REG_ALPHA: alpha_r <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      rtab_pkg::REG_TINT:  cfg_prdata = {16'd0, tint_r};
      rtab_pkg::REG_ALPHA: cfg_prdata = {23'd0, alpha_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // pipeline valid bits; a stage loads when it is empty or its successor moves
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  rtab_pkg::pipe_ctrl_t ctrl;

  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ctrl = '{ld1: rdy1, ld2: rdy2, ld3: rdy3};

  assign v1_nxt = rdy1 ? in_ch.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign in_ch.ready  = rdy1;
  assign out_ch.valid = v3_r;

  rtab_datapath u_datapath (
    .clk           (clk),
    .ctrl          (ctrl),
    .source_pixel  (in_ch.source_pixel),
    .dest_pixel    (in_ch.dest_pixel),
    .tint_color    (tint_r),
    .alpha_level   (alpha_r),
    .blended_pixel (out_ch.blended_pixel),
    .write_enable  (out_ch.write_enable)
  );

  // a result only appears when stage 2 held an item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without an item in stage 2");

  // a stalled result is neither dropped nor replaced
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ch.ready) |=> (v3_r && $stable(out_ch.blended_pixel)
                                 && $stable(out_ch.write_enable)))
    else $error("stalled result lost or changed");

  // a full middle stage never drops its item while the next one is blocked
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("stage 2 item lost during stall");

  a_tint_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[2] == rtab_pkg::REG_TINT)) |=> (tint_r == $past(cfg_pwdata[15:0])))
    else $error("tint register write failed");

  a_alpha_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[2] == rtab_pkg::REG_ALPHA)) |=> (alpha_r == $past(cfg_pwdata[8:0])))
    else $error("alpha register write failed");

endmodule
